@@ rtl/esc_arming_dshot_framer_macros.svh @@
// Assertion macros used by the framer RTL.
`ifndef ESC_ARMING_DSHOT_FRAMER_MACROS_SVH
`define ESC_ARMING_DSHOT_FRAMER_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is held.
`define EADF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that must also hold while reset is held.
`define EADF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/eadf_pkg.sv @@
// Types, constants and the frame function of the ESC arming DShot framer.
`default_nettype none

package eadf_pkg;

  localparam int unsigned LvlW      = 11;
  localparam int unsigned FrameW    = 16;
  localparam int unsigned ElapsedW  = 17;
  localparam int unsigned PowerUpW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxRes    = 4;
  localparam int unsigned CntW      = 3;
  localparam int unsigned ArmScale  = 6;

  localparam logic [PowerUpW-1:0] PowerUpRst = 16'd1000;
  localparam logic [LvlW-1:0]     LvlMinRst  = 11'd48;
  localparam logic [LvlW-1:0]     LvlMaxRst  = 11'd100;
  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegPowerUp = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLvlMin  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLvlMax  = 2'd2;

  // Input opcodes.
  localparam logic OpTick = 1'b0;
  localparam logic OpSet  = 1'b1;

  typedef struct packed {
    logic [1:0]        sel;
    logic [FrameW-1:0] frame;
    logic              armed;
    logic              last;
  } res_t;

  // Value, zero telemetry bit, then the XOR of the three nibbles of {value, 0}.
  function automatic logic [FrameW-1:0] make_frame(input logic [LvlW-1:0] value);
    logic [LvlW:0] word;
    logic [3:0]    cs;
    word = {value, 1'b0};
    cs   = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, cs};
  endfunction

endpackage

`default_nettype wire

@@ rtl/esc_arming_dshot_framer.sv @@
// ESC arming sequencer and DShot frame builder, top level.
//
// Channel  | Dir | Signals                                   | Carries
// s_axis   | in  | tvalid, tready, tdata[47:0], tuser[0:0]   | tick or set request
// m_axis   | out | tvalid, tready, tdata[15:0], tuser[2:0], tlast | one DShot frame
// cfg      | in  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// A request's frames are loaded into a four-entry result stage that drains
// one frame per cycle while m_axis_tready is high. A tick request gives at most
// one frame, so ticks flow one per cycle unless the output stalls; an armed set
// request gives min(MOTORS, 4) frames, so the next request waits until they drain.
// A new request is taken while the last pending frame leaves the result stage.
// Reset is asynchronous and active low; the configuration port is always ready.
`default_nettype none

module esc_arming_dshot_framer #(
  parameter int unsigned MOTORS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Requests.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // throttle_a, throttle_b, throttle_c, throttle_d, pad
  input  wire logic [0:0]  s_axis_tuser,   // opcode
  // Frames.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // frame_word
  output logic [2:0]       m_axis_tuser,   // motor_sel, is_armed
  output logic             m_axis_tlast
);

  localparam int unsigned PhW    = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int unsigned SetCnt = (MOTORS < eadf_pkg::MaxRes) ? MOTORS : eadf_pkg::MaxRes;
  localparam logic [PhW-1:0] PhLast = PhW'(MOTORS - 1);

  // Configuration registers.
  logic [eadf_pkg::PowerUpW-1:0] power_up_q;
  logic [eadf_pkg::LvlW-1:0]     lvl_min_q, lvl_max_q;

  // Sequencer state.
  logic [PhW-1:0]                phase_q, phase_d;
  logic [eadf_pkg::ElapsedW-1:0] elapsed_q, elapsed_d;
  logic                          armed_q, armed_d;
  logic                          rdown_q, rdown_d;
  logic [eadf_pkg::LvlW-1:0]     lvl_q [MOTORS];
  logic [eadf_pkg::LvlW-1:0]     lvl_d [MOTORS];

  // Result stage.
  eadf_pkg::res_t                ent_q [eadf_pkg::MaxRes];
  eadf_pkg::res_t                ent_d [eadf_pkg::MaxRes];
  logic [eadf_pkg::CntW-1:0]     cnt_q, cnt_d;

  logic                          in_acc, pop;
  logic [PhW-1:0]                phase_nx;
  logic [eadf_pkg::ElapsedW:0]   arm_thresh;
  logic [eadf_pkg::LvlW-1:0]     thr [eadf_pkg::MaxRes];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == eadf_pkg::CntW'(1)) && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = ent_q[0].frame;
  assign m_axis_tuser  = {ent_q[0].armed, ent_q[0].sel};
  assign m_axis_tlast  = ent_q[0].last;

  assign phase_nx   = (phase_q == PhLast) ? '0 : phase_q + PhW'(1);
  assign arm_thresh = (eadf_pkg::ElapsedW+1)'(power_up_q)
                    + (eadf_pkg::ElapsedW+1)'(lvl_max_q)
                    * (eadf_pkg::ElapsedW+1)'(eadf_pkg::ArmScale);

  always_comb begin
    for (int i = 0; i < eadf_pkg::MaxRes; i++) begin
      thr[i] = s_axis_tdata[i*eadf_pkg::LvlW +: eadf_pkg::LvlW];
    end
  end

  always_comb begin
    logic bump;
    logic ramp;
    logic [eadf_pkg::LvlW:0] up0;

    bump      = 1'b0;
    ramp      = 1'b0;
    up0       = {1'b0, lvl_q[0]} + (eadf_pkg::LvlW+1)'(1);
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    armed_d   = armed_q;
    rdown_d   = rdown_q;
    lvl_d     = lvl_q;
    ent_d     = ent_q;
    cnt_d     = pop ? cnt_q - eadf_pkg::CntW'(1) : cnt_q;

    if (pop) begin
      for (int i = 0; i < eadf_pkg::MaxRes - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end

    if (in_acc) begin
      if (s_axis_tuser[0] == eadf_pkg::OpTick) begin
        phase_d = phase_nx;
        if (elapsed_q < eadf_pkg::ElapsedW'(power_up_q)) begin
          bump = (phase_nx == '0);
        end else if (!armed_q) begin
          armed_d = ({1'b0, elapsed_q} > arm_thresh) && (phase_nx == PhLast);
          ent_d[0].sel   = 2'(phase_nx);
          ent_d[0].frame = eadf_pkg::make_frame(lvl_q[phase_nx]);
          ent_d[0].armed = armed_d;
          ent_d[0].last  = 1'b1;
          cnt_d          = eadf_pkg::CntW'(1);
          bump           = !armed_d && (phase_nx == '0);
          ramp           = bump;
        end
      end else if (armed_q) begin
        for (int i = 0; i < SetCnt; i++) begin
          lvl_d[i]       = thr[i];
          ent_d[i].sel   = 2'(i);
          ent_d[i].frame = eadf_pkg::make_frame(thr[i]);
          ent_d[i].armed = 1'b1;
          ent_d[i].last  = (i == SetCnt - 1);
        end
        cnt_d = eadf_pkg::CntW'(SetCnt);
      end
    end

    if (bump && (elapsed_q != eadf_pkg::ElapsedMax)) begin
      elapsed_d = elapsed_q + eadf_pkg::ElapsedW'(1);
    end

    // One ramp step: up by one until the peak is passed, then down to the floor.
    if (ramp) begin
      if (rdown_q) begin
        if (lvl_q[0] <= lvl_min_q) begin
          for (int i = 0; i < MOTORS; i++) lvl_d[i] = lvl_min_q;
        end else begin
          for (int i = 0; i < MOTORS; i++) begin
            lvl_d[i] = (lvl_q[i] == '0) ? '0 : lvl_q[i] - eadf_pkg::LvlW'(1);
          end
        end
      end else if (up0 > {1'b0, lvl_max_q}) begin
        for (int i = 0; i < MOTORS; i++) lvl_d[i] = lvl_max_q;
        rdown_d = 1'b1;
      end else begin
        for (int i = 0; i < MOTORS; i++) lvl_d[i] = lvl_q[i] + eadf_pkg::LvlW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_up_q <= eadf_pkg::PowerUpRst;
      lvl_min_q  <= eadf_pkg::LvlMinRst;
      lvl_max_q  <= eadf_pkg::LvlMaxRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        eadf_pkg::RegPowerUp: power_up_q <= cfg_data_i;
        eadf_pkg::RegLvlMin:  lvl_min_q  <= cfg_data_i[eadf_pkg::LvlW-1:0];
        eadf_pkg::RegLvlMax:  lvl_max_q  <= cfg_data_i[eadf_pkg::LvlW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      elapsed_q <= '0;
      armed_q   <= 1'b0;
      rdown_q   <= 1'b0;
      cnt_q     <= '0;
      for (int i = 0; i < MOTORS; i++) lvl_q[i] <= eadf_pkg::LvlMinRst;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      armed_q   <= armed_d;
      rdown_q   <= rdown_d;
      cnt_q     <= cnt_d;
      lvl_q     <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

`include "esc_arming_dshot_framer_macros.svh"

  `EADF_ASSERT(a_cnt_bound, cnt_q <= eadf_pkg::CntW'(SetCnt), "result stage overfilled")
  `EADF_ASSERT(a_armed_sticky, armed_q |=> armed_q, "armed flag dropped")
  `EADF_ASSERT(a_last_single, (m_axis_tvalid && m_axis_tlast) |-> (cnt_q == eadf_pkg::CntW'(1)), "last frame is not the final pending entry")
  `EADF_ASSERT(a_set_unarmed, (in_acc && s_axis_tuser[0] == eadf_pkg::OpSet && !armed_q) |=> (cnt_q == '0), "set request before arming produced frames")

endmodule

`default_nettype wire
